// ===== rtl/utc8_pkg.sv =====
// Shared types and constants for the UTF-16 to chunked CESU-8 string unit.
// No dependencies; every other file in rtl refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package utc8_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int MAX_BYTES   = 6;
	localparam int COUNT_W     = 3;

	localparam logic [14:0] CHUNK_FULL = 15'h7fff;

	localparam logic [15:0] UNIT_REPLACEMENT = 16'hfffd;
	localparam logic [15:0] UNIT_NONCHAR_E   = 16'hfffe;
	localparam logic [15:0] UNIT_NONCHAR_F   = 16'hffff;
	localparam logic [15:0] UNIT_BOM         = 16'hfeff;
	localparam logic [15:0] UNIT_WORD_JOINER = 16'h2060;

	localparam logic [7:0] LEAD_TWO   = 8'hc0;
	localparam logic [7:0] LEAD_THREE = 8'he0;
	localparam logic [7:0] CONT_MARK  = 8'h80;
	localparam logic [7:0] CONT_MASK  = 8'h3f;

	localparam logic [7:0] MARK_STR_MORE = 8'h73; // 's'
	localparam logic [7:0] MARK_STR_LAST = 8'h53; // 'S'
	localparam logic [7:0] MARK_XML_MORE = 8'h78; // 'x'
	localparam logic [7:0] MARK_XML_LAST = 8'h58; // 'X'

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_UNIT  = 1'b1
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] code_unit;
		logic        is_xml;
		logic [23:0] total_length;
	} unit_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       end_of_string;
	} byte_item_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] units_remaining;
		logic [14:0]            chunk_units_left;
		logic                   xml_kind;
	} enc_state_t;

	// Bytes produced by one item, ready for the serialiser.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [COUNT_W-1:0]        count;
		logic                      eos;
	} enc_load_t;

endpackage

`default_nettype wire

// ===== rtl/utc8_encode.sv =====
// Combinational encoder: turns one registered item and the string state into
// the bytes it produces and the next state. Depends on utc8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utc8_encode (
	input  wire utc8_pkg::unit_item_t item,
	input  wire utc8_pkg::enc_state_t state,
	output utc8_pkg::enc_load_t       load,
	output utc8_pkg::enc_state_t      state_next
);

	typedef struct packed {
		logic [2:0][7:0] hdr;
		logic [14:0]     count;
	} header_t;

	function automatic header_t make_header(input logic [utc8_pkg::LENGTH_BITS-1:0] ur,
			input logic xml);
		header_t h;
		logic    more;
		more = (ur > utc8_pkg::LENGTH_BITS'(utc8_pkg::CHUNK_FULL));
		h.count = more ? utc8_pkg::CHUNK_FULL : ur[14:0];
		if (more) begin
			h.hdr[0] = xml ? utc8_pkg::MARK_XML_MORE : utc8_pkg::MARK_STR_MORE;
		end else begin
			h.hdr[0] = xml ? utc8_pkg::MARK_XML_LAST : utc8_pkg::MARK_STR_LAST;
		end
		h.hdr[1] = {1'b0, h.count[14:8]};
		h.hdr[2] = h.count[7:0];
		return h;
	endfunction

	always_comb begin
		logic [15:0]                     w;
		logic [utc8_pkg::LENGTH_BITS-1:0] ur_dec;
		logic [14:0]                     cl_dec;
		logic [utc8_pkg::COUNT_W-1:0]     k;
		header_t                         h;

		load       = '0;
		state_next = state;
		w          = item.code_unit;
		ur_dec     = state.units_remaining - utc8_pkg::LENGTH_BITS'(1);
		cl_dec     = state.chunk_units_left - 15'd1;
		k          = '0;
		h          = '0;

		if (item.func == utc8_pkg::FUNC_START) begin
			h                          = make_header(item.total_length, item.is_xml);
			state_next.xml_kind        = item.is_xml;
			state_next.units_remaining = item.total_length;
			state_next.chunk_units_left = h.count;
			load.bytes[0] = h.hdr[0];
			load.bytes[1] = h.hdr[1];
			load.bytes[2] = h.hdr[2];
			load.count    = utc8_pkg::COUNT_W'(3);
			load.eos      = (item.total_length == '0);
		end else if (state.units_remaining != '0) begin
			if (w == utc8_pkg::UNIT_NONCHAR_E || w == utc8_pkg::UNIT_NONCHAR_F) begin
				w = utc8_pkg::UNIT_REPLACEMENT;
			end else if (w == utc8_pkg::UNIT_BOM) begin
				w = utc8_pkg::UNIT_WORD_JOINER;
			end

			if (w < 16'h0080) begin
				load.bytes[0] = w[7:0];
				k = utc8_pkg::COUNT_W'(1);
			end else if (w < 16'h0800) begin
				load.bytes[0] = utc8_pkg::LEAD_TWO | {3'b000, w[10:6]};
				load.bytes[1] = utc8_pkg::CONT_MARK | (w[7:0] & utc8_pkg::CONT_MASK);
				k = utc8_pkg::COUNT_W'(2);
			end else begin
				load.bytes[0] = utc8_pkg::LEAD_THREE | {4'b0000, w[15:12]};
				load.bytes[1] = utc8_pkg::CONT_MARK | (w[13:6] & utc8_pkg::CONT_MASK);
				load.bytes[2] = utc8_pkg::CONT_MARK | (w[7:0] & utc8_pkg::CONT_MASK);
				k = utc8_pkg::COUNT_W'(3);
			end

			state_next.units_remaining  = ur_dec;
			state_next.chunk_units_left = cl_dec;
			load.count = k;
			load.eos   = (ur_dec == '0);

			// A unit that closes a chunk with units still to come opens the next one.
			if (ur_dec != '0 && cl_dec == 15'd0) begin
				h = make_header(ur_dec, state.xml_kind);
				state_next.chunk_units_left = h.count;
				load.count = k + utc8_pkg::COUNT_W'(3);
				case (k)
					utc8_pkg::COUNT_W'(1): begin
						load.bytes[1] = h.hdr[0];
						load.bytes[2] = h.hdr[1];
						load.bytes[3] = h.hdr[2];
					end
					utc8_pkg::COUNT_W'(2): begin
						load.bytes[2] = h.hdr[0];
						load.bytes[3] = h.hdr[1];
						load.bytes[4] = h.hdr[2];
					end
					default: begin
						load.bytes[3] = h.hdr[0];
						load.bytes[4] = h.hdr[1];
						load.bytes[5] = h.hdr[2];
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/utc8_serial.sv =====
// Result register and byte serialiser: holds the bytes of one item and sends
// them one word per cycle while enc_stall is low. Depends on utc8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utc8_serial (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      load_valid,
	input  wire utc8_pkg::enc_load_t load,
	output logic                     can_load,
	output logic                     enc_valid,
	input  wire                      enc_stall,
	output utc8_pkg::byte_item_t     enc_word
);

	utc8_pkg::enc_load_t          buf_q;
	logic [utc8_pkg::COUNT_W-1:0] idx_q;
	logic                         valid_q;
	logic                         at_end;

	assign at_end   = (idx_q == buf_q.count - utc8_pkg::COUNT_W'(1));
	assign can_load = !valid_q || (!enc_stall && at_end);

	assign enc_valid              = valid_q;
	assign enc_word.out_byte      = buf_q.bytes[idx_q];
	assign enc_word.last          = at_end;
	assign enc_word.end_of_string = at_end && buf_q.eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load_valid) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && !enc_stall) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + utc8_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid) begin
			buf_q <= load;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (buf_q.count != '0 && idx_q < buf_q.count))
		else $error("serialiser index beyond the loaded byte count");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(enc_valid && !enc_stall && !enc_word.last) |=> enc_valid)
		else $error("item cut short before its last byte");

	a_load_ok: assert property (@(posedge clk) disable iff (!arst_n)
		load_valid |-> (can_load && load.count != '0))
		else $error("serialiser loaded while busy or with no bytes");

endmodule

`default_nettype wire

// ===== rtl/utf16_to_cesu8_chunked_string_unit.sv =====
// Top level of the UTF-16 to chunked CESU-8 string unit: input register,
// string state, encoder and serialiser. Depends on utc8_pkg, utc8_encode, utc8_serial.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes words of two kinds. A start word (func 0) opens a string of
// total_length UTF-16 units, of string or xml kind, and yields the first chunk
// header: a marker byte and a 16-bit big-endian count. A unit word (func 1)
// yields one to three CESU-8 bytes, followed by the next chunk header when it
// closes a chunk of 0x7fff units and more units remain; a unit word with no
// open string yields nothing. Each result word carries one byte; last marks the
// final byte of an input word and end_of_string the final byte of the string.
// Timing: an accepted word is registered in the input stage, encoded there
// combinationally and loaded into the result register once it is free or is
// sending its last byte. The output sends one byte per cycle while enc_stall
// is low, one to six bytes for each input word, and the next word is loaded
// as the last byte of the one before leaves. A dropped unit word leaves the
// input stage without a load. There is no clearing pass after reset.

module utf16_to_cesu8_chunked_string_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       unit_valid,
	output logic                      unit_stall,
	input  wire utc8_pkg::unit_item_t unit_word,
	output logic                      enc_valid,
	input  wire                       enc_stall,
	output utc8_pkg::byte_item_t      enc_word
);

	// Input register stage.
	logic                 valid_s1;
	utc8_pkg::unit_item_t item_s1;

	// String state: units left, units left in the chunk, marker kind.
	utc8_pkg::enc_state_t state_q;
	utc8_pkg::enc_state_t state_next;
	utc8_pkg::enc_load_t  load;

	logic can_load;
	logic produces;
	logic advance;
	logic accept;

	utc8_encode u_encode (
		.item       (item_s1),
		.state      (state_q),
		.load       (load),
		.state_next (state_next)
	);

	// A word that yields no bytes leaves the input stage at once; otherwise it
	// waits until the result register is free or about to be emptied.
	assign produces   = (load.count != '0);
	assign advance    = valid_s1 && (can_load || !produces);
	assign unit_stall = valid_s1 && !advance;
	assign accept     = unit_valid && !unit_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= unit_word;
		end
	end

	utc8_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (advance && produces),
		.load       (load),
		.can_load   (can_load),
		.enc_valid  (enc_valid),
		.enc_stall  (enc_stall),
		.enc_word   (enc_word)
	);

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		unit_stall |-> valid_s1)
		else $error("input stalled with the input stage empty");

	a_start_sets_length: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.func == utc8_pkg::FUNC_START)
		|=> (state_q.units_remaining == $past(item_s1.total_length)))
		else $error("start word did not load the string length");

	a_drop_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.func == utc8_pkg::FUNC_UNIT && state_q.units_remaining == '0)
		|=> (state_q == $past(state_q)))
		else $error("unit word with no open string changed the state");

endmodule

`default_nettype wire
